// ===== hw/rtl/wtok_pkg.sv =====
`default_nettype none
package wtok_pkg;

  // default sizes
  localparam int unsigned TableSizeDef = 4096;
  localparam int unsigned WordMaxDef   = 64;
  localparam int unsigned MaxTokensDef = 256;
  localparam int unsigned TextCharsDef = 4096;

  localparam logic [31:0] HashSeed   = 32'd5381;
  localparam int unsigned QueueDepth = 8;

  // opcodes of the input channel
  localparam logic [1:0] OpText   = 2'd0;
  localparam logic [1:0] OpVocab  = 2'd1;
  localparam logic [1:0] OpLookup = 2'd2;

  // configuration register indexes
  localparam logic CfgUnkId = 1'b0;
  localparam logic CfgEosId = 1'b1;

  typedef enum logic [1:0] {
    CMD_APPEND,
    CMD_RESOLVE,
    CMD_EOS
  } cmd_kind_e;

  // command from front to back; pos holds the length on a resolve
  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  data;
    logic [6:0]  pos;
    logic [31:0] hash;
    logic        may_insert;
    logic        lastr;
  } cmd_t;

  function automatic cmd_t mk_cmd(cmd_kind_e kind, logic [7:0] data, logic [6:0] pos,
                                  logic [31:0] hash, logic may_insert, logic lastr);
    cmd_t c;
    c.kind       = kind;
    c.data       = data;
    c.pos        = pos;
    c.hash       = hash;
    c.may_insert = may_insert;
    c.lastr      = lastr;
    return c;
  endfunction

  function automatic logic [7:0] fold(logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c inside {[8'h41:8'h5a]}) r = c + 8'd32;
    return r;
  endfunction

  function automatic logic is_word_byte(logic [7:0] c);
    return (c inside {[8'h61:8'h7a], [8'h30:8'h39], 8'h27});
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/wtok_if.sv =====
`default_nettype none
interface wtok_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] char_byte;
  logic       last;
  modport source (output valid, opcode, char_byte, last, input ready);
  modport sink   (input valid, opcode, char_byte, last, output ready);
endinterface

interface wtok_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] token_id;
  logic        is_new;
  logic        table_full;
  logic        last_res;
  modport source (output valid, token_id, is_new, table_full, last_res, input ready);
  modport sink   (input valid, token_id, is_new, table_full, last_res, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/wtok_front.sv =====
`default_nettype none
module wtok_front #(
  parameter int unsigned WORD_MAX   = wtok_pkg::WordMaxDef,
  parameter int unsigned MAX_TOKENS = wtok_pkg::MaxTokensDef,
  parameter int unsigned TEXT_CHARS = wtok_pkg::TextCharsDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  wtok_in_if.sink            in_i,
  input  wire logic          space_ok_i,
  output wtok_pkg::cmd_t     cmd_o [3],
  output logic [1:0]         push_n_o
);
  localparam int unsigned LW = $clog2(WORD_MAX);
  localparam int unsigned EW = (MAX_TOKENS > 2) ? $clog2(MAX_TOKENS) : 1;
  localparam int unsigned CW = $clog2(TEXT_CHARS);

  logic [LW-1:0] wl_q, wl_d;
  logic [31:0]   h_q, h_d;
  logic [EW-1:0] ec_q, ec_d;
  logic [CW-1:0] sc_q, sc_d;
  logic          accept;

  assign in_i.ready = space_ok_i;
  assign accept     = in_i.valid && space_ok_i;

  // classify the byte and turn it into commands for the back
  always_comb begin
    logic [7:0] c;
    logic [1:0] n;
    c    = wtok_pkg::fold(in_i.char_byte);
    n    = 2'd0;
    wl_d = wl_q;
    h_d  = h_q;
    ec_d = ec_q;
    sc_d = sc_q;
    for (int i = 0; i < 3; i++) begin
      cmd_o[i] = wtok_pkg::mk_cmd(wtok_pkg::CMD_EOS, 8'd0, 7'd0, 32'd0, 1'b0, 1'b0);
    end
    if (accept) begin
      if (in_i.opcode == wtok_pkg::OpVocab || in_i.opcode == wtok_pkg::OpLookup) begin
        if (wl_d < LW'(WORD_MAX - 1)) begin
          cmd_o[n] = wtok_pkg::mk_cmd(wtok_pkg::CMD_APPEND, c, 7'(wl_d), 32'd0, 1'b0, 1'b0);
          n    = n + 2'd1;
          wl_d = wl_d + LW'(1);
          h_d  = (h_d << 5) + h_d + 32'(c);
        end
        if (in_i.last) begin
          cmd_o[n] = wtok_pkg::mk_cmd(wtok_pkg::CMD_RESOLVE, 8'd0, 7'(wl_d), h_d,
                                      in_i.opcode == wtok_pkg::OpVocab, 1'b1);
          n    = n + 2'd1;
          wl_d = '0;
          h_d  = wtok_pkg::HashSeed;
        end
      end else if (in_i.opcode == wtok_pkg::OpText) begin
        if (sc_d < CW'(TEXT_CHARS - 1)) begin
          sc_d = sc_d + CW'(1);
          if (wtok_pkg::is_word_byte(c)) begin
            if (ec_d < EW'(MAX_TOKENS - 1)) begin
              if (wl_d < LW'(WORD_MAX - 1)) begin
                cmd_o[n] = wtok_pkg::mk_cmd(wtok_pkg::CMD_APPEND, c, 7'(wl_d), 32'd0,
                                            1'b0, 1'b0);
                n    = n + 2'd1;
                wl_d = wl_d + LW'(1);
                h_d  = (h_d << 5) + h_d + 32'(c);
              end
              if (wl_d >= LW'(WORD_MAX - 1)) begin
                cmd_o[n] = wtok_pkg::mk_cmd(wtok_pkg::CMD_RESOLVE, 8'd0, 7'(wl_d), h_d,
                                            1'b1, !in_i.last);
                n    = n + 2'd1;
                ec_d = ec_d + EW'(1);
                wl_d = '0;
                h_d  = wtok_pkg::HashSeed;
              end
            end
          end else if (wl_d != '0) begin
            if (ec_d < EW'(MAX_TOKENS - 1)) begin
              cmd_o[n] = wtok_pkg::mk_cmd(wtok_pkg::CMD_RESOLVE, 8'd0, 7'(wl_d), h_d,
                                          1'b1, !in_i.last);
              n    = n + 2'd1;
              ec_d = ec_d + EW'(1);
            end
            wl_d = '0;
            h_d  = wtok_pkg::HashSeed;
          end
        end
        if (in_i.last) begin
          if (wl_d != '0 && ec_d < EW'(MAX_TOKENS - 1)) begin
            cmd_o[n] = wtok_pkg::mk_cmd(wtok_pkg::CMD_RESOLVE, 8'd0, 7'(wl_d), h_d,
                                        1'b1, 1'b0);
            n = n + 2'd1;
          end
          cmd_o[n] = wtok_pkg::mk_cmd(wtok_pkg::CMD_EOS, 8'd0, 7'd0, 32'd0, 1'b0, 1'b1);
          n    = n + 2'd1;
          wl_d = '0;
          h_d  = wtok_pkg::HashSeed;
          ec_d = '0;
          sc_d = '0;
        end
      end
    end
    push_n_o = n;
  end

  // word and string counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q <= '0;
      h_q  <= wtok_pkg::HashSeed;
      ec_q <= '0;
      sc_q <= '0;
    end else begin
      wl_q <= wl_d;
      h_q  <= h_d;
      ec_q <= ec_d;
      sc_q <= sc_d;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/wtok_cmdq.sv =====
`default_nettype none
module wtok_cmdq (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire wtok_pkg::cmd_t push_cmd_i [3],
  input  wire logic [1:0]     push_n_i,
  input  wire logic           pop_i,
  output wtok_pkg::cmd_t      head_o,
  output logic                empty_o,
  output logic                space_ok_o
);
  localparam int unsigned D  = wtok_pkg::QueueDepth;
  localparam int unsigned PW = $clog2(D);

  wtok_pkg::cmd_t mem_q [D];
  logic [PW-1:0]  wp_q, rp_q;
  logic [PW:0]    cnt_q;

  assign head_o     = mem_q[rp_q];
  assign empty_o    = (cnt_q == '0);
  assign space_ok_o = (cnt_q <= (PW+1)'(D - 3));

  // up to three entries written per cycle
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < push_n_i) mem_q[wp_q + PW'(i)] <= push_cmd_i[i];
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + PW'(push_n_i);
      rp_q  <= rp_q + PW'(pop_i);
      cnt_q <= cnt_q + (PW+1)'(push_n_i) - (PW+1)'(pop_i);
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/wtok_back.sv =====
`default_nettype none
module wtok_back #(
  parameter int unsigned TABLE_SIZE = wtok_pkg::TableSizeDef,
  parameter int unsigned WORD_MAX   = wtok_pkg::WordMaxDef
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire wtok_pkg::cmd_t head_i,
  input  wire logic           empty_i,
  output logic                pop_o,
  output logic                ready_o,
  input  wire logic [11:0]    unk_id_i,
  input  wire logic [11:0]    eos_id_i,
  wtok_out_if.source          out_o
);
  localparam int unsigned SW    = $clog2(TABLE_SIZE);
  localparam int unsigned LW    = $clog2(WORD_MAX);
  localparam int unsigned VW    = $clog2(TABLE_SIZE + 1);
  localparam int unsigned CAW   = $clog2(TABLE_SIZE * WORD_MAX);
  localparam int unsigned MW    = 1 + LW + 12;
  localparam bit          IsPow = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MOD, S_PRD, S_PCHK, S_CRD, S_CCHK, S_IRD, S_IWR, S_IMETA, S_EMIT
  } state_e;

  state_e        state_q;
  logic [SW-1:0] slot_q, clr_q, slot_nx;
  logic [VW-1:0] probe_q, vc_q;
  logic [LW-1:0] k_q, wlen_q;
  logic [31:0]   hash_q;
  logic          mcnt_q;
  logic [SW+1:0] rsum_q, rsum, rred;
  logic [SW-1:0] res_tbl [4][256];
  logic          may_q, lastr_q;
  logic [11:0]   res_tok_q;
  logic          res_new_q, res_full_q, res_last_q;
  logic          ov_q;

  // memories: slot metadata, slot characters, word buffer
  logic [MW-1:0] meta_mem [TABLE_SIZE];
  logic [7:0]    chr_mem  [TABLE_SIZE * WORD_MAX];
  logic [7:0]    wb_mem   [WORD_MAX];
  logic [MW-1:0] meta_rd_q;
  logic [7:0]    chr_rd_q, wb_rd_q;
  logic          meta_we;
  logic [SW-1:0] meta_wa;
  logic [MW-1:0] meta_wd;
  logic [CAW-1:0] chr_addr;
  logic          m_used;
  logic [LW-1:0] m_len;
  logic [11:0]   m_tok;

  assign {m_used, m_len, m_tok} = meta_rd_q;
  assign chr_addr = CAW'(slot_q) * CAW'(WORD_MAX) + CAW'(k_q);
  assign slot_nx  = (slot_q == SW'(TABLE_SIZE - 1)) ? '0 : slot_q + SW'(1);
  assign ready_o  = (state_q != S_CLEAR);
  assign pop_o    = (state_q == S_IDLE) && !empty_i;

  // residue of each hash byte at its weight, modulo the table size
  for (genvar gk = 0; gk < 4; gk++) begin : g_res
    for (genvar gb = 0; gb < 256; gb++) begin : g_byte
      assign res_tbl[gk][gb] = SW'((64'(gb) << (8 * gk)) % 64'(TABLE_SIZE));
    end
  end

  // slot index unit: byte residues summed, then at most two subtractions
  always_comb begin
    rsum = (SW+2)'(res_tbl[0][hash_q[7:0]]) + (SW+2)'(res_tbl[1][hash_q[15:8]]) +
           (SW+2)'(res_tbl[2][hash_q[23:16]]) + (SW+2)'(res_tbl[3][hash_q[31:24]]);
    rred = rsum_q;
    if (rred >= (SW+2)'(2 * TABLE_SIZE)) rred = rred - (SW+2)'(2 * TABLE_SIZE);
    if (rred >= (SW+2)'(TABLE_SIZE)) rred = rred - (SW+2)'(TABLE_SIZE);
  end

  // metadata write port
  always_comb begin
    meta_we = 1'b0;
    meta_wa = slot_q;
    meta_wd = {1'b1, wlen_q, 12'(vc_q)};
    if (state_q == S_CLEAR) begin
      meta_we = 1'b1;
      meta_wa = clr_q;
      meta_wd = '0;
    end else if (state_q == S_IMETA) begin
      meta_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (meta_we) meta_mem[meta_wa] <= meta_wd;
    if (state_q == S_PRD) meta_rd_q <= meta_mem[slot_q];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IWR) chr_mem[chr_addr] <= wb_rd_q;
    if (state_q == S_CRD) chr_rd_q <= chr_mem[chr_addr];
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && head_i.kind == wtok_pkg::CMD_APPEND) wb_mem[LW'(head_i.pos)] <= head_i.data;
    if (state_q == S_CRD || state_q == S_IRD) wb_rd_q <= wb_mem[k_q];
  end

  // sequencer: clearing pass, probing, compare, insert, result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_q      <= '0;
      slot_q     <= '0;
      probe_q    <= '0;
      vc_q       <= '0;
      k_q        <= '0;
      wlen_q     <= '0;
      hash_q     <= '0;
      mcnt_q     <= 1'b0;
      rsum_q     <= '0;
      may_q      <= 1'b0;
      lastr_q    <= 1'b0;
      res_tok_q  <= '0;
      res_new_q  <= 1'b0;
      res_full_q <= 1'b0;
      res_last_q <= 1'b0;
      ov_q       <= 1'b0;
      out_o.token_id   <= '0;
      out_o.is_new     <= 1'b0;
      out_o.table_full <= 1'b0;
      out_o.last_res   <= 1'b0;
    end else begin
      if (ov_q && out_o.ready && state_q != S_EMIT) ov_q <= 1'b0;
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + SW'(1);
          if (clr_q == SW'(TABLE_SIZE - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (!empty_i) begin
            case (head_i.kind)
              wtok_pkg::CMD_RESOLVE: begin
                wlen_q  <= LW'(head_i.pos);
                hash_q  <= head_i.hash;
                may_q   <= head_i.may_insert;
                lastr_q <= head_i.lastr;
                probe_q <= '0;
                mcnt_q  <= 1'b0;
                if (IsPow) begin
                  slot_q  <= head_i.hash[SW-1:0];
                  state_q <= S_PRD;
                end else begin
                  state_q <= S_MOD;
                end
              end
              wtok_pkg::CMD_EOS: begin
                res_tok_q  <= eos_id_i;
                res_new_q  <= 1'b0;
                res_full_q <= 1'b0;
                res_last_q <= 1'b1;
                state_q    <= S_EMIT;
              end
              default: ;
            endcase
          end
        end
        S_MOD: begin
          if (!mcnt_q) begin
            rsum_q <= rsum;
            mcnt_q <= 1'b1;
          end else begin
            slot_q  <= rred[SW-1:0];
            state_q <= S_PRD;
          end
        end
        S_PRD: state_q <= S_PCHK;
        S_PCHK: begin
          k_q <= '0;
          if (!m_used) begin
            if (may_q) begin
              state_q <= (wlen_q == '0) ? S_IMETA : S_IRD;
            end else begin
              res_tok_q  <= unk_id_i;
              res_new_q  <= 1'b0;
              res_full_q <= 1'b0;
              res_last_q <= lastr_q;
              state_q    <= S_EMIT;
            end
          end else if (m_len == wlen_q && wlen_q == '0) begin
            res_tok_q  <= m_tok;
            res_new_q  <= 1'b0;
            res_full_q <= 1'b0;
            res_last_q <= lastr_q;
            state_q    <= S_EMIT;
          end else if (m_len == wlen_q) begin
            state_q <= S_CRD;
          end else if (probe_q + VW'(1) == VW'(TABLE_SIZE)) begin
            res_tok_q  <= unk_id_i;
            res_new_q  <= 1'b0;
            res_full_q <= may_q;
            res_last_q <= lastr_q;
            state_q    <= S_EMIT;
          end else begin
            probe_q <= probe_q + VW'(1);
            slot_q  <= slot_nx;
            state_q <= S_PRD;
          end
        end
        S_CRD: state_q <= S_CCHK;
        S_CCHK: begin
          if (wb_rd_q != chr_rd_q) begin
            if (probe_q + VW'(1) == VW'(TABLE_SIZE)) begin
              res_tok_q  <= unk_id_i;
              res_new_q  <= 1'b0;
              res_full_q <= may_q;
              res_last_q <= lastr_q;
              state_q    <= S_EMIT;
            end else begin
              probe_q <= probe_q + VW'(1);
              slot_q  <= slot_nx;
              state_q <= S_PRD;
            end
          end else if (k_q + LW'(1) == wlen_q) begin
            res_tok_q  <= m_tok;
            res_new_q  <= 1'b0;
            res_full_q <= 1'b0;
            res_last_q <= lastr_q;
            state_q    <= S_EMIT;
          end else begin
            k_q     <= k_q + LW'(1);
            state_q <= S_CRD;
          end
        end
        S_IRD: state_q <= S_IWR;
        S_IWR: begin
          k_q     <= k_q + LW'(1);
          state_q <= (k_q + LW'(1) == wlen_q) ? S_IMETA : S_IRD;
        end
        S_IMETA: begin
          res_tok_q  <= 12'(vc_q);
          res_new_q  <= 1'b1;
          res_full_q <= 1'b0;
          res_last_q <= lastr_q;
          vc_q       <= vc_q + VW'(1);
          state_q    <= S_EMIT;
        end
        S_EMIT: begin
          if (!ov_q || out_o.ready) begin
            ov_q             <= 1'b1;
            out_o.token_id   <= res_tok_q;
            out_o.is_new     <= res_new_q;
            out_o.table_full <= res_full_q;
            out_o.last_res   <= res_last_q;
            state_q          <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid = ov_q;

  a_no_pop_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> !pop_o) else $error("command taken during clearing pass");
  a_vc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vc_q <= VW'(TABLE_SIZE)) else $error("vocabulary count beyond table");
  a_insert_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IMETA |-> vc_q < VW'(TABLE_SIZE)) else $error("insert into full table");

endmodule
`default_nettype wire

// ===== hw/rtl/word_tokenizer_hash_vocab.sv =====
// results: an end of string is answered straight from the queue; a word lookup reads and checks
//   each probed slot, then compares its characters one by one; an insert copies the word per character
// throughput: one request a cycle while the command queue has room; the back sequencer
//   (single port slot memories) sets the sustained rate
// reset: asynchronous, active low; a clearing pass over all TABLE_SIZE slots follows in
//   which no request is taken; configuration writes are taken throughout
`default_nettype none
module word_tokenizer_hash_vocab #(
  parameter int unsigned TABLE_SIZE = wtok_pkg::TableSizeDef,
  parameter int unsigned WORD_MAX   = wtok_pkg::WordMaxDef,
  parameter int unsigned MAX_TOKENS = wtok_pkg::MaxTokensDef,
  parameter int unsigned TEXT_CHARS = wtok_pkg::TextCharsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  wtok_in_if.sink          in_i,
  wtok_out_if.source       out_o,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [11:0] cfg_data_i
);
  logic [11:0]    unk_q, eos_q;
  wtok_pkg::cmd_t push_cmd [3];
  wtok_pkg::cmd_t head;
  logic [1:0]     push_n;
  logic           pop, empty, space_ok, back_ready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unk_q <= 12'd0;
      eos_q <= 12'd3;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == wtok_pkg::CfgUnkId) unk_q <= cfg_data_i;
      if (cfg_idx_i == wtok_pkg::CfgEosId) eos_q <= cfg_data_i;
    end
  end

  wtok_front #(
    .WORD_MAX(WORD_MAX), .MAX_TOKENS(MAX_TOKENS), .TEXT_CHARS(TEXT_CHARS)
  ) u_front (
    .clk_i, .rst_ni, .in_i,
    .space_ok_i(space_ok && back_ready),
    .cmd_o(push_cmd), .push_n_o(push_n)
  );

  wtok_cmdq u_cmdq (
    .clk_i, .rst_ni,
    .push_cmd_i(push_cmd), .push_n_i(push_n), .pop_i(pop),
    .head_o(head), .empty_o(empty), .space_ok_o(space_ok)
  );

  wtok_back #(
    .TABLE_SIZE(TABLE_SIZE), .WORD_MAX(WORD_MAX)
  ) u_back (
    .clk_i, .rst_ni,
    .head_i(head), .empty_i(empty), .pop_o(pop), .ready_o(back_ready),
    .unk_id_i(unk_q), .eos_id_i(eos_q), .out_o
  );

endmodule
`default_nettype wire

// ===== tb/word_tokenizer_hash_vocab_test.sv =====
`timescale 1ns / 100ps
module word_tokenizer_hash_vocab_test;

  localparam int unsigned TableSize  = wtok_pkg::TableSizeDef;
  localparam int unsigned WordMax    = wtok_pkg::WordMaxDef;
  localparam int unsigned MaxTokens  = wtok_pkg::MaxTokensDef;
  localparam int unsigned TextChars  = wtok_pkg::TextCharsDef;
  localparam int unsigned CycleLimit = 6000000;
  localparam int unsigned SettleCycles = 64;
  localparam int unsigned RandomItems = 100;
  localparam logic [1:0]  OpIgnored  = 2'd3;

  typedef struct packed {
    logic [11:0] token_id;
    logic        is_new;
    logic        table_full;
    logic        last_res;
  } token_res_t;

  typedef enum int {PROBE_FOUND, PROBE_FREE, PROBE_NONE} probe_e;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_idx_i;
  logic [11:0] cfg_data_i;

  wtok_in_if  in_if ();
  wtok_out_if out_if ();

  word_tokenizer_hash_vocab DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // vocabulary model state
  logic [11:0] unk_val, eos_val;
  bit          slot_used [TableSize];
  logic [7:0]  slot_chars [TableSize][WordMax];
  int unsigned slot_len [TableSize];
  logic [11:0] slot_tok [TableSize];
  int unsigned vocab_count;
  logic [7:0]  word_buf [WordMax];
  int unsigned word_len;
  logic [31:0] word_hash;
  int unsigned emitted_cnt;
  int unsigned text_cnt;

  token_res_t expected_tokens [$];
  int unsigned error_cnt;
  int unsigned cycle_cnt;
  int unsigned burst_left;

  function automatic logic [7:0] lower_case(logic [7:0] c);
    if (c >= "A" && c <= "Z") return c + 8'd32;
    return c;
  endfunction

  function automatic bit word_char(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "0" && c <= "9") || c == "'";
  endfunction

  function automatic void clear_word();
    word_len  = 0;
    word_hash = wtok_pkg::HashSeed;
  endfunction

  function automatic void append_char(logic [7:0] c);
    if (word_len >= WordMax - 1) return;
    word_buf[word_len] = c;
    word_len++;
    word_hash = (word_hash << 5) + word_hash + c;
  endfunction

  // linear probing from the hash slot
  function automatic probe_e probe_table(output int unsigned slot);
    int unsigned base;
    bit same;
    base = word_hash % TableSize;
    slot = base;
    for (int unsigned i = 0; i < TableSize; i++) begin
      slot = (base + i) % TableSize;
      if (!slot_used[slot]) return PROBE_FREE;
      if (slot_len[slot] == word_len) begin
        same = 1'b1;
        for (int unsigned j = 0; j < word_len; j++)
          if (slot_chars[slot][j] != word_buf[j]) same = 1'b0;
        if (same) return PROBE_FOUND;
      end
    end
    return PROBE_NONE;
  endfunction

  function automatic void push_token(logic [11:0] id, bit fresh, bit full, bit lastr);
    token_res_t r;
    r.token_id   = id;
    r.is_new     = fresh;
    r.table_full = full;
    r.last_res   = lastr;
    expected_tokens.push_back(r);
  endfunction

  // resolve the pending word into one expected token
  function automatic void resolve_word(bit may_insert, bit lastr);
    int unsigned s;
    probe_e p;
    p = probe_table(s);
    if (p == PROBE_FOUND) begin
      push_token(slot_tok[s], 1'b0, 1'b0, lastr);
    end else if (p == PROBE_FREE && may_insert) begin
      for (int unsigned j = 0; j < word_len; j++) slot_chars[s][j] = word_buf[j];
      slot_len[s]  = word_len;
      slot_tok[s]  = vocab_count[11:0];
      slot_used[s] = 1'b1;
      push_token(vocab_count[11:0], 1'b1, 1'b0, lastr);
      vocab_count++;
    end else begin
      push_token(unk_val, 1'b0, (p == PROBE_NONE) && may_insert, lastr);
    end
    clear_word();
  endfunction

  function automatic void tokenize_byte(logic [1:0] op, logic [7:0] raw, bit last);
    logic [7:0] c;
    c = lower_case(raw);
    if (op == wtok_pkg::OpVocab || op == wtok_pkg::OpLookup) begin
      append_char(c);
      if (last) resolve_word(op == wtok_pkg::OpVocab, 1'b1);
      return;
    end
    if (op != wtok_pkg::OpText) return;
    if (text_cnt < TextChars - 1) begin
      text_cnt++;
      if (word_char(c)) begin
        if (emitted_cnt < MaxTokens - 1) begin
          append_char(c);
          if (word_len >= WordMax - 1) begin
            resolve_word(1'b1, !last);
            emitted_cnt++;
          end
        end
      end else if (word_len > 0) begin
        if (emitted_cnt < MaxTokens - 1) begin
          resolve_word(1'b1, !last);
          emitted_cnt++;
        end else begin
          clear_word();
        end
      end
    end
    if (last) begin
      if (word_len > 0) begin
        if (emitted_cnt < MaxTokens - 1) resolve_word(1'b1, 1'b0);
        else clear_word();
      end
      push_token(eos_val, 1'b0, 1'b0, 1'b1);
      clear_word();
      emitted_cnt = 0;
      text_cnt    = 0;
    end
  endfunction

  // request sender with bursts and gaps
  task automatic send_byte(logic [1:0] op, logic [7:0] c, bit last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      repeat (gap) begin
        @(negedge clk_i);
        in_if.valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_if.valid     <= 1'b1;
    in_if.opcode    <= op;
    in_if.char_byte <= c;
    in_if.last      <= last;
    while (!in_if.ready) @(negedge clk_i);
    @(posedge clk_i);
    tokenize_byte(op, c, last);
  endtask

  task automatic send_string(logic [1:0] op, string s);
    for (int i = 0; i < s.len(); i++) send_byte(op, s[i], i == s.len() - 1);
  endtask

  // hold off until every expected token has come back
  task automatic drain();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (expected_tokens.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [11:0] val);
    drain();
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == wtok_pkg::CfgUnkId) unk_val = val;
    else eos_val = val;
  endtask

  // token receiver stalls in modes of its own
  int unsigned rdy_mode, rdy_span;
  always @(negedge clk_i) begin
    if (rdy_span == 0) begin
      rdy_mode = $urandom_range(0, 2);
      rdy_span = $urandom_range(20, 200);
    end
    rdy_span--;
    case (rdy_mode)
      0: out_if.ready <= 1'b1;
      1: out_if.ready <= ($urandom_range(0, 9) < 7);
      default: out_if.ready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  // token checker
  always @(posedge clk_i) begin
    token_res_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_tokens.size() == 0) begin
        $error("unexpected token id %0d", out_if.token_id);
        error_cnt++;
      end else begin
        want = expected_tokens.pop_front();
        if (out_if.token_id !== want.token_id) begin
          $error("token_id expected %0d actual %0d", want.token_id, out_if.token_id);
          error_cnt++;
        end
        if (out_if.is_new !== want.is_new) begin
          $error("is_new expected %0d actual %0d", want.is_new, out_if.is_new);
          error_cnt++;
        end
        if (out_if.table_full !== want.table_full) begin
          $error("table_full expected %0d actual %0d", want.table_full, out_if.table_full);
          error_cnt++;
        end
        if (out_if.last_res !== want.last_res) begin
          $error("last_res expected %0d actual %0d", want.last_res, out_if.last_res);
          error_cnt++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // text of words, cases, digits, apostrophe, zero byte and long words
  task automatic test_text_words();
    send_string(wtok_pkg::OpText, "Hello, World");
    send_string(wtok_pkg::OpText, " ");
    send_string(wtok_pkg::OpText, "Don't 42 HELLO hello");
    send_byte(wtok_pkg::OpText, 8'h00, 1'b0);
    send_byte(wtok_pkg::OpText, 8'hff, 1'b0);
    send_string(wtok_pkg::OpText, "cat.");
    repeat (70) send_byte(wtok_pkg::OpText, "q", 1'b0);
    send_string(wtok_pkg::OpText, "!x");
  endtask

  // vocabulary inserts, lookups, ignored opcode and shared word buffer
  task automatic test_vocab_lookup();
    send_byte(wtok_pkg::OpVocab, "C", 1'b0);
    send_byte(wtok_pkg::OpVocab, 8'h00, 1'b0);
    send_byte(wtok_pkg::OpVocab, " ", 1'b0);
    send_byte(wtok_pkg::OpVocab, "t", 1'b1);
    send_string(wtok_pkg::OpVocab, "cat");
    send_string(wtok_pkg::OpLookup, "HELLO");
    send_string(wtok_pkg::OpLookup, "unknown");
    send_byte(OpIgnored, 8'h80, 1'b1);
    repeat (66) send_byte(wtok_pkg::OpVocab, "Z", 1'b0);
    send_byte(wtok_pkg::OpVocab, "z", 1'b1);
    send_string(wtok_pkg::OpText, "ab");
    send_byte(wtok_pkg::OpLookup, "c", 1'b1);
    send_string(wtok_pkg::OpText, "ab");
    send_byte(wtok_pkg::OpVocab, "c", 1'b1);
    send_string(wtok_pkg::OpLookup, "abc");
  endtask

  task automatic test_config();
    write_reg(wtok_pkg::CfgUnkId, 12'hfff);
    write_reg(wtok_pkg::CfgEosId, 12'h000);
    send_string(wtok_pkg::OpLookup, "nothing");
    send_string(wtok_pkg::OpText, "cat dog");
    write_reg(wtok_pkg::CfgEosId, 12'hfff);
    write_reg(wtok_pkg::CfgUnkId, 12'h000);
    send_string(wtok_pkg::OpLookup, "nothing");
    send_string(wtok_pkg::OpText, "dog cat");
    write_reg(wtok_pkg::CfgUnkId, 12'h5a5);
    write_reg(wtok_pkg::CfgEosId, 12'h002);
  endtask

  // more than the token limit in one string
  task automatic test_token_limit();
    for (int i = 0; i < MaxTokens + 4; i++) begin
      send_byte(wtok_pkg::OpText, 8'("a" + (i % 3)), 1'b0);
      send_byte(wtok_pkg::OpText, " ", 1'b0);
    end
    send_byte(wtok_pkg::OpText, "b", 1'b1);
    send_string(wtok_pkg::OpText, "a b");
  endtask

  task automatic random_word(output string s);
    string dict [16] = '{"the", "cat", "dog", "it's", "42", "a", "zebra", "x9",
                        "hello", "world", "don't", "q", "apple", "7up", "rain", "z'"};
    s = dict[$urandom_range(0, 15)];
    for (int i = 0; i < s.len(); i++)
      if (s[i] >= "a" && s[i] <= "z" && $urandom_range(0, 2) == 0) s[i] = s[i] - 8'd32;
  endtask

  task automatic test_random();
    int unsigned sent, kind, nw, len;
    string w;
    logic [1:0] op;
    sent = 0;
    while (sent < RandomItems) begin
      kind = $urandom_range(0, 99);
      if (kind < 65) begin
        nw = $urandom_range(1, 8);
        for (int k = 0; k < nw; k++) begin
          random_word(w);
          for (int i = 0; i < w.len(); i++) send_byte(wtok_pkg::OpText, w[i], 1'b0);
          sent += w.len() + 1;
          if (k == nw - 1 && $urandom_range(0, 1)) begin
            send_byte(wtok_pkg::OpText, 8'($urandom_range(0, 255)), 1'b1);
          end else if ($urandom_range(0, 3) == 0) begin
            send_byte(wtok_pkg::OpText, 8'($urandom_range(0, 255)), k == nw - 1);
          end else begin
            send_byte(wtok_pkg::OpText, " ", k == nw - 1);
          end
        end
      end else if (kind < 85) begin
        op = (kind < 75) ? wtok_pkg::OpVocab : wtok_pkg::OpLookup;
        if ($urandom_range(0, 1)) begin
          random_word(w);
          send_string(op, w);
          sent += w.len();
        end else begin
          len = $urandom_range(1, 5);
          for (int i = 0; i < len; i++)
            send_byte(op, 8'($urandom_range(0, 255)), i == len - 1);
          sent += len;
        end
      end else if (kind < 95) begin
        op = 2'($urandom_range(0, 2));
        send_byte(op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        send_byte(OpIgnored, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = wtok_pkg::CfgUnkId;
    cfg_data_i    = '0;
    in_if.valid     = 1'b0;
    in_if.opcode    = wtok_pkg::OpText;
    in_if.char_byte = '0;
    in_if.last      = 1'b0;
    out_if.ready  = 1'b0;
    rdy_span      = 0;
    error_cnt     = 0;
    cycle_cnt     = 0;
    burst_left    = 0;
    unk_val       = 12'd0;
    eos_val       = 12'd3;
    vocab_count   = 0;
    emitted_cnt   = 0;
    text_cnt      = 0;
    clear_word();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_text_words();
    test_vocab_lookup();
    test_config();
    test_token_limit();
    test_random();

    drain();
    if (error_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
